### src/bfs_shortest_path_engine_assert.svh
// Assertion macros shared by the checker of the path engine.
// Depends on nothing; included by bfs_shortest_path_engine_checker.sv.
`ifndef BFS_SHORTEST_PATH_ENGINE_ASSERT_SVH
`define BFS_SHORTEST_PATH_ENGINE_ASSERT_SVH
`define BSP_ASSERT_IMPL(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BSP_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

### src/bsp_pkg.sv
// Package of the path engine: sizes, marks, state codes.
// Depends on nothing.
`default_nettype none
package bsp_pkg;
   localparam int MaxVertices = 64;
   localparam int MaxEdges    = 256;
   localparam int EntryCap    = 2 * MaxEdges;
   localparam int VW = $clog2(MaxVertices);
   localparam int EW = $clog2(EntryCap);
   localparam int CW = EW + 1;
   localparam logic [6:0] MarkUnvisited = 7'h7f;
   localparam logic [6:0] MarkRoot      = 7'h7e;

   typedef enum logic [3:0] {
      ST_IDLE, ST_APPEND, ST_LINK, ST_INIT, ST_POP, ST_HEAD, ST_FIRST, ST_ENTRY,
      ST_NBRD, ST_CHECK, ST_TRACE, ST_TRACE_RD, ST_EMIT_RD, ST_EMIT, ST_CLEAR
   } state_type;

   typedef struct packed {
      logic          we;
      logic [EW-1:0] addr;
      logic [VW-1:0] nb;
      logic          link_we;
      logic [EW-1:0] link_addr;
      logic [EW:0]   link;
   } entry_wr_type;
endpackage
`default_nettype wire

### src/bfs_shortest_path_engine.sv
// Top level of the BFS shortest path engine: control, vertex tables, output.
// Depends on bsp_pkg and bsp_entry_mem.
//
//  channel | dir | tdata / tuser
//  req     | in  | tdata[5:0] vertex_a, [11:6] vertex_b; tuser op
//  rsp     | out | tdata[5:0] hop_count, [11:6] path_vertex; tuser[0] found,
//          |     | tuser[1] overflow; tlast last
//  csr     | in  | index 0 vertex_count, 1 start_vertex, 2 end_vertex
//
// An edge item is handled per endpoint as one entry write and one link fixup;
// a dropped edge is only flagged as overflow. A search starts, pops the queue,
// visits the adjacency entries, traces the path vertices and emits the results,
// then runs a clearing pass over all 64 vertices of the vertex tables. Reset
// clears only control; the clearing pass runs after reset before the first item.
// Result stalls hold the sequencer.
`default_nettype none
module bfs_shortest_path_engine
   import bsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // vertex_a, vertex_b
   input  wire logic        req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // hop_count, path_vertex
   output logic [1:0]       rsp_tuser,   // found, overflow
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data
);
   localparam logic [1:0] RegCount = 2'd0;
   localparam logic [1:0] RegStart = 2'd1;
   localparam logic [1:0] RegEnd   = 2'd2;

   state_type state_ff, state_in;
   logic [6:0]    vcount_ff;
   logic [VW-1:0] start_ff, end_ff;
   logic [CW-1:0] used_ff, used_in, used_dec;
   logic          drop_ff, drop_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in;
   logic          half_ff, half_in;
   logic          fix_ff, fix_in;
   logic [EW-1:0] fix_addr_ff, fix_addr_in;
   logic [VW:0]   qh_ff, qh_in, qt_ff, qt_in;
   logic [VW-1:0] y_ff, y_in;
   logic [EW:0]   e_ff, e_in;
   logic [VW-1:0] v_ff, v_in;
   logic [VW:0]   len_ff, len_in, k_ff, k_in;
   logic [VW:0]   clr_ff, clr_in;
   logic          ok_ff, ok_in;

   // vertex tables; head, tail and mark share one address, all read registered
   logic [EW:0]   head_mem [MaxVertices];
   logic [EW-1:0] tail_mem [MaxVertices];
   logic [6:0]    mark_mem [MaxVertices];
   logic [VW-1:0] queue_mem [MaxVertices];
   logic [VW-1:0] path_mem [MaxVertices];

   logic [VW-1:0] vt_addr;
   logic [EW:0]   head_rd;
   logic [EW-1:0] tail_rd;
   logic [6:0]    mark_rd;
   logic          head_we, tail_we, mark_we;
   logic [EW:0]   head_wd;
   logic [EW-1:0] tail_wd;
   logic [6:0]    mark_wd;
   logic [VW-1:0] q_raddr, q_rd, q_waddr, q_wd;
   logic          q_we;
   logic [VW-1:0] p_raddr, p_rd, p_waddr, p_wd;
   logic          p_we;

   entry_wr_type  ewr;
   logic [EW-1:0] e_raddr;
   logic [VW-1:0] e_nb;
   logic [EW:0]   e_link;

   logic [6:0]    n_eff;
   logic          out_v_ff, out_v_in, out_last_ff, out_last_in, out_found_ff;
   logic          out_found_in, out_ovf_ff, out_ovf_in;
   logic [VW-1:0] out_hop_ff, out_hop_in, out_pv_ff, out_pv_in;
   logic          out_free;
   logic          emit_last;
   logic [EW:0]   no_link;

   assign no_link = {1'b1, {EW{1'b1}}};
   assign n_eff = (vcount_ff == 7'd0) ? 7'd1 :
                  (vcount_ff > 7'(MaxVertices)) ? 7'(MaxVertices) : vcount_ff;
   assign out_free = !out_v_ff || rsp_tready;
   assign used_dec = used_ff - CW'(1);
   assign emit_last = !ok_ff || (k_ff + (VW+1)'(1) == len_ff);

   always_ff @(posedge clock) begin
      if (head_we) head_mem[vt_addr] <= head_wd;
      if (tail_we) tail_mem[vt_addr] <= tail_wd;
      if (mark_we) mark_mem[vt_addr] <= mark_wd;
      head_rd <= head_mem[vt_addr];
      tail_rd <= tail_mem[vt_addr];
      mark_rd <= mark_mem[vt_addr];
   end

   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_waddr] <= q_wd;
      q_rd <= queue_mem[q_raddr];
      if (p_we) path_mem[p_waddr] <= p_wd;
      p_rd <= path_mem[p_raddr];
   end

   bsp_entry_mem u_entry (
      .clock   (clock),
      .wr      (ewr),
      .rd_addr (e_raddr),
      .rd_nb   (e_nb),
      .rd_link (e_link)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         vcount_ff <= 7'd64;
         start_ff <= '0;
         end_ff <= '0;
         used_ff <= '0;
         drop_ff <= 1'b0;
         clr_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         drop_ff <= drop_in;
         clr_ff <= clr_in;
         out_v_ff <= out_v_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               RegCount: vcount_ff <= csr_data;
               RegStart: start_ff <= csr_data[VW-1:0];
               RegEnd:   end_ff <= csr_data[VW-1:0];
               default:  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; half_ff <= half_in;
      fix_ff <= fix_in; fix_addr_ff <= fix_addr_in;
      qh_ff <= qh_in; qt_ff <= qt_in; y_ff <= y_in; e_ff <= e_in;
      v_ff <= v_in; len_ff <= len_in; k_ff <= k_in; ok_ff <= ok_in;
      out_last_ff <= out_last_in; out_found_ff <= out_found_in;
      out_ovf_ff <= out_ovf_in; out_hop_ff <= out_hop_in; out_pv_ff <= out_pv_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser) begin
                  if (req_tdata[5:0] >= n_eff[VW-1:0] && n_eff != 7'(MaxVertices)
                      || req_tdata[11:6] >= n_eff[VW-1:0]
                         && n_eff != 7'(MaxVertices)
                      || used_ff + CW'(2) > CW'(EntryCap))
                     state_in = ST_IDLE;
                  else
                     state_in = ST_APPEND;
               end else if (start_ff < n_eff[VW-1:0] || n_eff == 7'(MaxVertices)) begin
                  if ((end_ff < n_eff[VW-1:0] || n_eff == 7'(MaxVertices))
                      && start_ff != end_ff)
                     state_in = ST_INIT;
                  else
                     state_in = ST_EMIT;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_APPEND: state_in = ST_LINK;
         ST_LINK:   state_in = half_ff ? ST_IDLE : ST_APPEND;
         ST_INIT:   state_in = ST_POP;
         ST_POP:    state_in = (qh_ff < qt_ff) ? ST_HEAD : ST_EMIT;
         ST_HEAD:   state_in = ST_FIRST;
         ST_FIRST:  state_in = ST_ENTRY;
         ST_ENTRY:  state_in = (e_ff == no_link) ? ST_POP : ST_NBRD;
         ST_NBRD:   state_in = ST_CHECK;
         ST_CHECK: begin
            if (mark_rd == MarkUnvisited && e_nb == end_ff) state_in = ST_TRACE;
            else state_in = ST_ENTRY;
         end
         ST_TRACE:  state_in = ST_TRACE_RD;
         ST_TRACE_RD: begin
            if (mark_rd == MarkRoot || len_ff == (VW+1)'(MaxVertices)) state_in = ST_EMIT;
            else state_in = ST_TRACE;
         end
         ST_EMIT_RD: state_in = ST_EMIT;
         ST_EMIT:   if (out_free) state_in = emit_last ? ST_CLEAR : ST_EMIT_RD;
         ST_CLEAR:  if (clr_ff == (VW+1)'(MaxVertices - 1)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      csr_ready = 1'b1;
      used_in = used_ff; drop_in = drop_ff; clr_in = clr_ff;
      a_in = a_ff; b_in = b_ff; half_in = half_ff;
      fix_in = fix_ff; fix_addr_in = fix_addr_ff;
      qh_in = qh_ff; qt_in = qt_ff; y_in = y_ff; e_in = e_ff;
      v_in = v_ff; len_in = len_ff; k_in = k_ff; ok_in = ok_ff;
      out_v_in = out_v_ff && !rsp_tready;
      out_last_in = out_last_ff; out_found_in = out_found_ff;
      out_ovf_in = out_ovf_ff; out_hop_in = out_hop_ff; out_pv_in = out_pv_ff;
      vt_addr = a_ff;
      head_we = 1'b0; tail_we = 1'b0; mark_we = 1'b0;
      head_wd = '0; tail_wd = '0; mark_wd = MarkUnvisited;
      q_raddr = qh_ff[VW-1:0]; q_we = 1'b0; q_waddr = qt_ff[VW-1:0]; q_wd = '0;
      p_raddr = VW'(len_ff - (VW+1)'(1) - k_ff);
      p_we = 1'b0; p_waddr = len_ff[VW-1:0]; p_wd = v_ff;
      ewr = '0;
      e_raddr = e_ff[EW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            a_in = req_tdata[5:0];
            b_in = req_tdata[11:6];
            half_in = 1'b0;
            vt_addr = req_tdata[5:0];
            ok_in = 1'b0;
            if (req_tvalid && !req_tuser && state_in == ST_IDLE) drop_in = 1'b1;
            if (req_tvalid && req_tuser) begin
               len_in = '0;
               k_in = '0;
            end
         end
         ST_APPEND: begin
            // head/tail of the current vertex were read last cycle
            vt_addr = half_ff ? b_ff : a_ff;
            ewr.we = 1'b1;
            ewr.addr = used_ff[EW-1:0];
            ewr.nb = half_ff ? a_ff : b_ff;
            ewr.link_we = 1'b1;
            ewr.link_addr = used_ff[EW-1:0];
            ewr.link = no_link;
            tail_we = 1'b1;
            tail_wd = used_ff[EW-1:0];
            fix_in = (head_rd != no_link);
            fix_addr_in = tail_rd;
            if (head_rd == no_link) begin
               head_we = 1'b1;
               head_wd = {1'b0, used_ff[EW-1:0]};
            end
            used_in = used_ff + CW'(1);
         end
         ST_LINK: begin
            // old tail points to the new entry; read the second endpoint
            vt_addr = b_ff;
            if (fix_ff) begin
               ewr.link_we = 1'b1;
               ewr.link_addr = fix_addr_ff;
               ewr.link = {1'b0, used_dec[EW-1:0]};
            end
            half_in = 1'b1;
         end
         ST_INIT: begin
            vt_addr = start_ff;
            mark_we = 1'b1;
            mark_wd = MarkRoot;
            q_we = 1'b1; q_waddr = '0; q_wd = start_ff;
            qh_in = '0; qt_in = (VW+1)'(1);
         end
         ST_POP: ;
         ST_HEAD: begin
            y_in = q_rd;
            vt_addr = q_rd;
            qh_in = qh_ff + (VW+1)'(1);
         end
         ST_FIRST: begin
            e_in = head_rd;
         end
         ST_ENTRY: ;
         ST_NBRD: begin
            vt_addr = e_nb;
         end
         ST_CHECK: begin
            vt_addr = e_nb;
            e_in = e_link;
            if (mark_rd == MarkUnvisited) begin
               mark_we = 1'b1;
               mark_wd = {1'b0, y_ff};
               if (qt_ff < (VW+1)'(MaxVertices)) begin
                  q_we = 1'b1; q_wd = e_nb; qt_in = qt_ff + (VW+1)'(1);
               end
               if (e_nb == end_ff) v_in = end_ff;
            end
         end
         ST_TRACE: begin
            vt_addr = v_ff;
            p_we = 1'b1;
            len_in = len_ff + (VW+1)'(1);
         end
         ST_TRACE_RD: begin
            vt_addr = v_ff;
            v_in = mark_rd[VW-1:0];
            ok_in = 1'b1;
         end
         ST_EMIT_RD: ;
         ST_EMIT: begin
            if (out_free) begin
               out_v_in = 1'b1;
               out_ovf_in = drop_ff;
               out_found_in = ok_ff;
               out_hop_in = ok_ff ? VW'(len_ff - (VW+1)'(1)) : '0;
               out_pv_in = ok_ff ? p_rd : '0;
               out_last_in = emit_last;
               k_in = k_ff + (VW+1)'(1);
            end
         end
         ST_CLEAR: begin
            vt_addr = clr_ff[VW-1:0];
            head_we = 1'b1; head_wd = no_link;
            mark_we = 1'b1; mark_wd = MarkUnvisited;
            clr_in = clr_ff + (VW+1)'(1);
            used_in = '0;
            drop_in = 1'b0;
         end
         default: ;
      endcase
      if (state_ff == ST_CLEAR && state_in == ST_IDLE) clr_in = '0;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'd0, out_pv_ff, out_hop_ff};
   assign rsp_tuser  = {out_ovf_ff, out_found_ff};
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

### src/bsp_entry_mem.sv
// Adjacency entry store: neighbor and next-link memories, registered reads.
// Depends on bsp_pkg.
`default_nettype none
module bsp_entry_mem
   import bsp_pkg::*;
(
   input  wire logic          clock,
   input  wire entry_wr_type  wr,
   input  wire logic [EW-1:0] rd_addr,
   output logic [VW-1:0]      rd_nb,
   output logic [EW:0]        rd_link
);
   logic [VW-1:0] nb_mem [EntryCap];
   logic [EW:0]   link_mem [EntryCap];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         nb_mem[wr.addr] <= wr.nb;
      end
      rd_nb <= nb_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[wr.link_addr] <= wr.link;
      end
      rd_link <= link_mem[rd_addr];
   end
endmodule
`default_nettype wire

### src/bfs_shortest_path_engine_checker.sv
// Port-level checker for the path engine, bound to the top level.
// Depends on bfs_shortest_path_engine_assert.svh.
`include "bfs_shortest_path_engine_assert.svh"
`default_nettype none
module bfs_shortest_path_engine_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   `BSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `BSP_ASSERT_IMPL(a_nf_last, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
   `BSP_ASSERT_IMPL(a_nf_zero, clock, reset,
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'd0)
   `BSP_ASSERT_IMPL(a_no_take, clock, reset,
      rsp_tvalid && !rsp_tlast |-> !req_tready)
endmodule
bind bfs_shortest_path_engine bfs_shortest_path_engine_checker u_checker (.*);
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the BFS shortest path engine: loads edges over req,
// runs searches and compares each path item on rsp against an in-bench predictor.
// Depends on bsp_pkg and the bfs_shortest_path_engine RTL.
`default_nettype none
module tb;
   import bsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NoLink = -1;
   localparam logic OpEdge   = 1'b0;
   localparam logic OpSearch = 1'b1;
   localparam logic [1:0] RegCount = 2'd0;
   localparam logic [1:0] RegStart = 2'd1;
   localparam logic [1:0] RegEnd   = 2'd2;

   typedef struct {
      logic       op;
      logic [5:0] a;
      logic [5:0] b;
   } graph_item_type;

   typedef struct {
      logic       found;
      logic [5:0] hops;
      logic [5:0] vertex;
      logic       ovf;
      logic       last;
   } path_item_type;

   typedef struct {
      logic [1:0] index;
      logic [6:0] data;
   } csr_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   bfs_shortest_path_engine dut (.*);

   graph_item_type pending_items[$];
   path_item_type  expected_path[$];
   csr_write_type  pending_csr[$];
   int items_queued = 0;
   int items_taken = 0;
   int csr_queued = 0;
   int csr_taken = 0;
   int failures = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // shadow of the engine
   logic [6:0] sh_count = 7'd64;
   logic [5:0] sh_start = '0;
   logic [5:0] sh_end = '0;
   logic [5:0] sh_nbr[EntryCap];
   int         sh_next[EntryCap];
   int         sh_head[MaxVertices];
   int         sh_tail[MaxVertices];
   logic [6:0] sh_mark[MaxVertices];
   logic [5:0] sh_fifo[MaxVertices];
   int         sh_used = 0;
   logic       sh_dropped = 1'b0;

   function automatic void clear_shadow();
      for (int i = 0; i < MaxVertices; i++) begin
         sh_head[i] = NoLink;
         sh_mark[i] = MarkUnvisited;
      end
      sh_used = 0;
      sh_dropped = 1'b0;
   endfunction

   function automatic void link_entry(int v, logic [5:0] nb);
      sh_nbr[sh_used] = nb;
      sh_next[sh_used] = NoLink;
      if (sh_head[v] == NoLink) sh_head[v] = sh_used;
      else sh_next[sh_tail[v]] = sh_used;
      sh_tail[v] = sh_used;
      sh_used++;
   endfunction

   function automatic void predict_item(logic op, logic [5:0] a, logic [5:0] b);
      int n, qh, qt, y, e, v, len;
      logic ok;
      logic [5:0] nb;
      logic [5:0] route[MaxVertices];
      path_item_type r;
      n = (sh_count == 0) ? 1 : ((sh_count > MaxVertices) ? MaxVertices : sh_count);
      if (op == OpEdge) begin
         if (a >= n || b >= n || sh_used + 2 > EntryCap) begin
            sh_dropped = 1'b1;
         end else begin
            link_entry(a, b);
            link_entry(b, a);
         end
         return;
      end
      ok = 1'b0;
      if (sh_start < n && sh_end < n && sh_start != sh_end) begin
         qh = 0;
         qt = 1;
         sh_fifo[0] = sh_start;
         sh_mark[sh_start] = MarkRoot;
         while (qh < qt && !ok) begin
            y = sh_fifo[qh++];
            e = sh_head[y];
            while (e != NoLink && e < EntryCap && !ok) begin
               nb = sh_nbr[e];
               if (sh_mark[nb] == MarkUnvisited) begin
                  if (qt < MaxVertices) sh_fifo[qt++] = nb;
                  sh_mark[nb] = 7'(y);
                  if (nb == sh_end) ok = 1'b1;
               end
               e = sh_next[e];
            end
         end
      end
      if (ok) begin
         v = sh_end;
         len = 0;
         while (len < MaxVertices) begin
            route[len++] = 6'(v);
            if (sh_mark[v] == MarkRoot) break;
            v = sh_mark[v];
            if (v >= MaxVertices) break;
         end
         for (int k = 0; k < len; k++) begin
            r.found = 1'b1;
            r.hops = 6'(len - 1);
            r.vertex = route[len - 1 - k];
            r.ovf = sh_dropped;
            r.last = (k + 1 == len);
            expected_path.push_back(r);
         end
      end else begin
         r.found = 1'b0;
         r.hops = '0;
         r.vertex = '0;
         r.ovf = sh_dropped;
         r.last = 1'b1;
         expected_path.push_back(r);
      end
      clear_shadow();
   endfunction

   initial begin
      clear_shadow();
      forever #4 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_item(req_tuser, req_tdata[5:0], req_tdata[11:6]);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               graph_item_type it;
               it = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= it.op;
               req_tdata <= {4'b0, it.b, it.a};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegCount: sh_count = csr_data;
               RegStart: sh_start = csr_data[5:0];
               RegEnd:   sh_end = csr_data[5:0];
               default: ;
            endcase
            csr_taken++;
         end
         if (!csr_valid || csr_ready) begin
            if (pending_csr.size() > 0) begin
               csr_write_type w;
               w = pending_csr.pop_front();
               csr_valid <= 1'b1;
               csr_index <= w.index;
               csr_data <= w.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
         $error("%s expected %0d actual %0d", name, exp_val, got_val);
         failures++;
      end
   endfunction

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_path.size() == 0) begin
               $error("unexpected item found %0d vertex %0d", rsp_tuser[0], rsp_tdata[11:6]);
               failures++;
            end else begin
               path_item_type x;
               x = expected_path.pop_front();
               check_field("found", x.found, rsp_tuser[0]);
               check_field("hop_count", x.hops, rsp_tdata[5:0]);
               check_field("path_vertex", x.vertex, rsp_tdata[11:6]);
               check_field("overflow", x.ovf, rsp_tuser[1]);
               check_field("last", x.last, rsp_tlast);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic edge_item(logic [5:0] a, logic [5:0] b);
      graph_item_type it;
      it.op = OpEdge;
      it.a = a;
      it.b = b;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic search_item();
      graph_item_type it;
      it.op = OpSearch;
      it.a = 6'($urandom);
      it.b = 6'($urandom);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic drain();
      wait (items_taken == items_queued && expected_path.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_regs(logic [6:0] cnt, logic [5:0] s, logic [5:0] e);
      csr_write_type w;
      w.index = RegCount; w.data = cnt;     pending_csr.push_back(w);
      w.index = RegStart; w.data = {1'b0, s}; pending_csr.push_back(w);
      w.index = RegEnd;   w.data = {1'b0, e}; pending_csr.push_back(w);
      csr_queued += 3;
      wait (csr_taken == csr_queued);
   endtask

   function automatic logic [5:0] pick_vertex(int n);
      if ($urandom_range(0, 9) == 0) return 6'($urandom);
      return 6'($urandom_range(0, (n > 64 ? 64 : (n == 0 ? 1 : n)) - 1));
   endfunction

   initial begin
      int n, groups, edges;
      logic [6:0] cnt;
      logic [5:0] s, e;
      send_idle_pct = 15;
      recv_idle_pct = 65;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty graph, extreme vertices, self loop
      set_regs(7'd64, 6'd0, 6'd63);
      search_item();
      edge_item(6'd0, 6'd1);
      edge_item(6'd1, 6'd63);
      edge_item(6'd0, 6'd0);
      edge_item(6'd63, 6'd63);
      search_item();
      drain();
      // count 0 acts as 1, out-of-range endpoint dropped
      set_regs(7'd0, 6'd0, 6'd0);
      edge_item(6'd0, 6'd0);
      edge_item(6'd1, 6'd0);
      search_item();
      drain();
      // count above the maximum, search from the top vertex
      set_regs(7'd127, 6'd63, 6'd0);
      edge_item(6'd63, 6'd5);
      edge_item(6'd5, 6'd0);
      search_item();
      drain();
      // start equals end, then start out of range
      set_regs(7'd64, 6'd5, 6'd5);
      edge_item(6'd5, 6'd6);
      search_item();
      drain();
      set_regs(7'd10, 6'd12, 6'd3);
      edge_item(6'd9, 6'd9);
      edge_item(6'd10, 6'd2);
      search_item();
      drain();
      // edges kept from a larger vertex count
      set_regs(7'd64, 6'd1, 6'd2);
      edge_item(6'd1, 6'd40);
      edge_item(6'd40, 6'd2);
      drain();
      set_regs(7'd20, 6'd1, 6'd2);
      search_item();
      drain();

      // capacity overflow
      set_regs(7'd64, 6'd0, 6'd63);
      for (int i = 0; i < 258; i++) edge_item(i % 64, (i + 1) % 64);
      search_item();
      drain();

      while (items_queued < 480) begin
         if (items_queued < 330) begin
            send_idle_pct = 65;
            recv_idle_pct = 15;
         end
         if (items_queued > 410) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(0, 7))
            0: cnt = 7'd1;
            1: cnt = 7'd64;
            2: cnt = 7'($urandom);
            default: cnt = 7'($urandom_range(3, 16));
         endcase
         n = (cnt == 0) ? 1 : cnt;
         s = pick_vertex(n);
         e = pick_vertex(n);
         set_regs(cnt, s, e);
         groups = $urandom_range(1, 3);
         for (int g = 0; g < groups; g++) begin
            if (items_queued >= 480) break;
            edges = $urandom_range(0, 2 * (n > 16 ? 16 : n));
            for (int k = 0; k < edges; k++) edge_item(pick_vertex(n), pick_vertex(n));
            search_item();
         end
         drain();
      end

      if (failures == 0 && expected_path.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
